[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the tone generator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define DSTG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DSTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dstg_pkg.sv]
// ----------------------------------------------------------------------------
// dstg_pkg
// Constants and types shared by the decaying sine tone generator files.
// ----------------------------------------------------------------------------
`default_nettype none

package dstg_pkg;

    // Payload widths that are fixed by the item format.
    localparam int PHASE_INC_BITS = 32;
    localparam int AMP_BITS       = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    typedef logic [AMP_BITS-1:0]       t_amp;

    localparam t_cfg_index CFG_DECAY_FACTOR      = 2'd0;
    localparam t_cfg_index CFG_SILENCE_THRESHOLD = 2'd1;

    localparam t_amp DECAY_FACTOR_RESET      = 16'd65077;
    localparam t_amp SILENCE_THRESHOLD_RESET = 16'd7;

    // Item operation codes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    // Fixed-point constants for building the sine table.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          Q30_ONE     = 64'sd1073741824;
    localparam longint          Q30_HALF    = 64'sd536870912;

endpackage

`default_nettype wire

[sv/dstg_in_if.sv]
// ----------------------------------------------------------------------------
// dstg_in_if
// Input channel of the tone generator: tick and trigger items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dstg_in_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic [dstg_pkg::PHASE_INC_BITS-1:0]  phase_increment;
    logic [dstg_pkg::AMP_BITS-1:0]        start_amplitude;

    modport source (
        output valid,
        output operation,
        output phase_increment,
        output start_amplitude,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  phase_increment,
        input  start_amplitude,
        output ready
    );

endinterface

`default_nettype wire

[sv/dstg_out_if.sv]
// ----------------------------------------------------------------------------
// dstg_out_if
// Output channel of the tone generator: one signed sample per tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface dstg_out_if #(
    parameter int SAMPLE_BITS = 16
);

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          silent;

    modport source (
        output valid,
        output sample,
        output silent,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample,
        input  silent,
        output ready
    );

endinterface

`default_nettype wire

[sv/decaying_sine_tone_generator_top.sv]
// ----------------------------------------------------------------------------
// decaying_sine_tone_generator_top
// Wavetable sine oscillator with a phase accumulator and a decaying envelope.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on i_in. A trigger transaction loads a new phase step and a
// start amplitude and returns nothing. A tick transaction returns one signed
// sample on o_out, together with a silent flag that is set when the envelope
// amplitude has fallen below the silence threshold; a silent tick returns a
// zero sample and leaves the oscillator state untouched.
// The two configuration registers (decay factor, silence threshold) are
// written through i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// Timing: one item is accepted per cycle while i_in.ready is high. A tick's
// sample passes the registered read of the sine table, then the envelope
// scaling into the output register. The phase add and the envelope multiply
// close a loop on the oscillator state through its own registers, which is what
// allows the rate of one item per cycle.
// Reset clears the phase, the phase step and the envelope, loads the default
// register values and empties the pipeline. The sine table is a constant
// ROM, so no clearing pass is needed and items are accepted right away.
// When the receiver stalls, the output register holds its sample and one more
// tick can still move into the table stage; after that i_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module decaying_sine_tone_generator_top #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int PHASE_BITS    = 32,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dstg_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [dstg_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    dstg_in_if.sink                                  i_in,
    dstg_out_if.source                               o_out
);

    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int IDX_PROD_BITS = PHASE_BITS + IDX_BITS + 1;
    localparam int AMP_BITS      = dstg_pkg::AMP_BITS;
    localparam int SCALE_BITS    = SAMPLE_BITS + AMP_BITS + 1;
    localparam longint SAMPLE_PEAK = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_rom [TABLE_ENTRIES];

    // ------------------------------------------------------------------------
    // Sine table contents, built at elaboration. The sine of the folded
    // first-quadrant angle comes from a Q30 Taylor series of thirteen terms.
    // ------------------------------------------------------------------------
    function automatic longint sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 342; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 420; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 506; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 600; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > dstg_pkg::Q30_ONE) begin
            sum = dstg_pkg::Q30_ONE;
        end
        return sum;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rom_entry(input longint unsigned i);
        longint unsigned n;
        longint unsigned m;
        longint unsigned x;
        logic            neg;
        longint          v;
        n   = longint'(TABLE_ENTRIES);
        m   = 4 * i;
        neg = 1'b0;
        if (m >= 2 * n) begin
            neg = 1'b1;
            m   = m - 2 * n;
        end
        if (m > n) begin
            m = 2 * n - m;
        end
        x = (dstg_pkg::HALF_PI_Q30 * m) / TABLE_ENTRIES;
        v = (sin_q30(x) * SAMPLE_PEAK + dstg_pkg::Q30_HALF) >>> 30;
        if (neg) begin
            v = -v;
        end
        return SAMPLE_BITS'(v);
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            rom[i] = rom_entry(longint'(i));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [AMP_BITS-1:0]           r_decay;
    logic [AMP_BITS-1:0]           r_threshold;
    logic [PHASE_BITS-1:0]         r_phase;
    logic [PHASE_BITS-1:0]         r_step;
    logic [AMP_BITS-1:0]           r_amp;

    // Table stage: the ROM read register plus the amplitude that goes with it.
    logic                          r_s1_valid;
    logic                          r_s1_silent;
    logic [AMP_BITS-1:0]           r_s1_amp;
    logic signed [SAMPLE_BITS-1:0] r_rom_q;

    // Output register.
    logic                          r_out_valid;
    logic                          r_out_silent;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    // ------------------------------------------------------------------------
    // Flow control and datapath
    // ------------------------------------------------------------------------
    logic                          w_out_free;
    logic                          w_s1_free;
    logic                          w_tick;
    logic                          w_trigger;
    logic                          w_quiet;
    logic [IDX_PROD_BITS-1:0]      w_idx_prod;
    logic [IDX_BITS-1:0]           w_idx;
    logic [2*AMP_BITS-1:0]         w_decay_prod;
    logic [PHASE_BITS-1:0]         w_step_in;
    logic signed [SCALE_BITS-1:0]  w_scale_prod;
    logic signed [SAMPLE_BITS-1:0] w_scaled;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign i_in.ready = w_s1_free;

    assign w_tick    = i_in.valid && w_s1_free && (i_in.operation == dstg_pkg::OP_TICK);
    assign w_trigger = i_in.valid && w_s1_free && (i_in.operation == dstg_pkg::OP_TRIGGER);

    assign w_quiet = r_amp < r_threshold;

    // Table index is the phase scaled to the table length; for a power-of-two
    // length this reduces to the top phase bits.
    assign w_idx_prod = IDX_PROD_BITS'(r_phase) * IDX_PROD_BITS'(TABLE_ENTRIES);
    assign w_idx      = w_idx_prod[PHASE_BITS +: IDX_BITS];

    assign w_decay_prod = r_amp * r_decay;
    assign w_step_in    = PHASE_BITS'(i_in.phase_increment);

    // Arithmetic shift of the product rounds toward minus infinity.
    assign w_scale_prod = r_rom_q * $signed({1'b0, r_s1_amp});
    assign w_scaled     = w_scale_prod[SAMPLE_BITS+AMP_BITS-1:AMP_BITS];

    // Control state, configuration and oscillator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= dstg_pkg::DECAY_FACTOR_RESET;
            r_threshold <= dstg_pkg::SILENCE_THRESHOLD_RESET;
            r_phase     <= '0;
            r_step      <= '0;
            r_amp       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dstg_pkg::CFG_DECAY_FACTOR:      r_decay     <= i_cfg_data;
                    dstg_pkg::CFG_SILENCE_THRESHOLD: r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_trigger) begin
                r_step <= w_step_in;
                r_amp  <= i_in.start_amplitude;
            end else if (w_tick && !w_quiet) begin
                r_phase <= r_phase + r_step;
                r_amp   <= w_decay_prod[2*AMP_BITS-1:AMP_BITS];
            end
            if (w_s1_free) begin
                r_s1_valid <= w_tick;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers, including the synchronous table read.
    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1_silent <= w_quiet;
            r_s1_amp    <= r_amp;
            r_rom_q     <= SINE_ROM[w_idx];
        end
        if (w_out_free) begin
            r_out_silent <= r_s1_silent;
            r_out_sample <= r_s1_silent ? '0 : w_scaled;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_out_sample;
    assign o_out.silent = r_out_silent;

endmodule

`default_nettype wire

[sv/dstg_checker.sv]
// ----------------------------------------------------------------------------
// dstg_checker
// Port-level checks of the tone generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dstg_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] i_out_sample,
    input wire logic                          i_out_silent
);

    // A sample that waits for the receiver stays offered.
    `DSTG_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output valid dropped while stalled")

    // A silent tick must carry a zero sample.
    `DSTG_ASSERT(a_silent_zero, i_clk, i_rst_n, i_out_valid && i_out_silent |-> i_out_sample == '0, "silent sample is not zero")

    // Reset empties the pipeline.
    `DSTG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind decaying_sine_tone_generator_top dstg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_dstg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample),
    .i_out_silent (o_out.silent)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decaying sine tone generator. Trigger and tick
// transactions are driven with random gaps while the sample receiver stalls at
// random. A scoreboard keeps its own oscillator state and sine table, predicts
// every tick's sample and silent flag, and checks the results in order.
// ----------------------------------------------------------------------------

module tb;

    localparam int TABLE_SIZE    = 1024;
    localparam int PHASE_W       = 32;
    localparam int SAMPLE_W      = 16;
    localparam int SINE_PEAK     = (2 ** (SAMPLE_W - 1)) - 1;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENT_ITEMS = 165;
    localparam int NUM_SEGMENTS  = 6;
    localparam int PRESSURE_SEG  = 4;
    localparam int REPORT_LIMIT  = 10;

    // Register indexes past the end of the register list; writes to them
    // must leave the block untouched.
    localparam dstg_pkg::t_cfg_index CFG_SPARE_A = 2'd2;
    localparam dstg_pkg::t_cfg_index CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       silent;
    } t_tone_sample;

    // Scoreboard: mirrors the oscillator (phase, step, envelope, registers),
    // turns each accepted transaction into the expected sample, and compares
    // the samples leaving the block against those expectations in order.
    class t_tone_sample_board;
        int                 sine_rom [TABLE_SIZE];
        logic [PHASE_W-1:0] phase_acc;
        logic [PHASE_W-1:0] phase_step;
        logic [15:0]        envelope;
        logic [15:0]        decay_factor;
        logic [15:0]        silence_threshold;
        t_tone_sample       expected_samples [$];
        int                 error_count;

        function new();
            int i;
            for (i = 0; i < TABLE_SIZE; i++) begin
                sine_rom[i] = rom_value(i);
            end
            phase_acc         = '0;
            phase_step        = '0;
            envelope          = '0;
            decay_factor      = dstg_pkg::DECAY_FACTOR_RESET;
            silence_threshold = dstg_pkg::SILENCE_THRESHOLD_RESET;
            error_count       = 0;
        endfunction

        // Taylor series of sin in Q30 for a first-quadrant angle, clamped to [0, 1].
        function longint sine_q30(longint unsigned angle);
            longint unsigned angle_sq;
            longint unsigned term;
            longint          acc;
            int              n;
            angle_sq = (angle * angle) >> 30;
            term     = angle;
            acc      = longint'(angle);
            for (n = 1; n <= 12; n++) begin
                term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > dstg_pkg::Q30_ONE) begin
                acc = dstg_pkg::Q30_ONE;
            end
            return acc;
        endfunction

        // Table entry: the angle is folded into the first quadrant, the sign is
        // restored for the second half of the turn, and the value is rounded.
        function int rom_value(int slot);
            longint unsigned quarter_pos;
            longint unsigned angle;
            longint          magnitude;
            bit              negative;
            negative    = 1'b0;
            quarter_pos = 64'(4 * slot);
            if (quarter_pos >= 2 * TABLE_SIZE) begin
                negative    = 1'b1;
                quarter_pos = quarter_pos - 2 * TABLE_SIZE;
            end
            if (quarter_pos > TABLE_SIZE) begin
                quarter_pos = 2 * TABLE_SIZE - quarter_pos;
            end
            angle     = (dstg_pkg::HALF_PI_Q30 * quarter_pos) / TABLE_SIZE;
            magnitude = (sine_q30(angle) * SINE_PEAK + dstg_pkg::Q30_HALF) >>> 30;
            return negative ? -int'(magnitude) : int'(magnitude);
        endfunction

        function void set_register(dstg_pkg::t_cfg_index index, logic [15:0] value);
            case (index)
                dstg_pkg::CFG_DECAY_FACTOR:      decay_factor = value;
                dstg_pkg::CFG_SILENCE_THRESHOLD: silence_threshold = value;
                default: ;
            endcase
        endfunction

        function void take_item(logic operation, logic [PHASE_W-1:0] increment,
                                logic [15:0] amplitude);
            t_tone_sample next_sample;
            longint       product;
            longint       scaled;
            logic [31:0]  env_product;
            int           slot;
            if (operation == dstg_pkg::OP_TRIGGER) begin
                phase_step = increment;
                envelope   = amplitude;
                return;
            end
            if (envelope < silence_threshold) begin
                // Silent tick: zero sample and the oscillator stays frozen.
                next_sample.sample = '0;
                next_sample.silent = 1'b1;
            end else begin
                slot    = int'((64'(phase_acc) * 64'(TABLE_SIZE)) >> PHASE_W);
                product = longint'(sine_rom[slot]) * longint'(envelope);
                // Arithmetic shift floors toward minus infinity.
                scaled  = product >>> 16;
                next_sample.sample = scaled[SAMPLE_W-1:0];
                next_sample.silent = 1'b0;
                phase_acc   = phase_acc + phase_step;
                env_product = envelope * decay_factor;
                envelope    = env_product[31:16];
            end
            expected_samples.push_back(next_sample);
        endfunction

        function void note_error(string text);
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("[%0t] ERROR: %s", $time, text);
            end
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] sample, logic silent);
            t_tone_sample want;
            if (expected_samples.size() == 0) begin
                note_error($sformatf("unexpected sample %0d silent %0b", sample, silent));
                return;
            end
            want = expected_samples.pop_front();
            if (sample !== want.sample || silent !== want.silent) begin
                note_error($sformatf("sample %0d silent %0b, expected sample %0d silent %0b",
                                     sample, silent, want.sample, want.silent));
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    dstg_pkg::t_cfg_index               cfg_index;
    logic [dstg_pkg::CFG_DATA_BITS-1:0] cfg_data;

    dstg_in_if                                in_ch ();
    dstg_out_if #(.SAMPLE_BITS(SAMPLE_W))     out_ch ();

    // Idle percentages of the two sides; they change from phase to phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The stimulus raises hold_request; the receiver process then keeps ready
    // low for a long stretch, counting the cycles itself.
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int cycle_count  = 0;

    t_tone_sample_board board;

    decaying_sine_tone_generator_top #(
        .TABLE_ENTRIES(TABLE_SIZE),
        .PHASE_BITS   (PHASE_W),
        .SAMPLE_BITS  (SAMPLE_W)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Hard stop in case the block hangs or loses a transaction.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Transaction monitor. Both channels are sampled at the rising edge, where
    // the values seen are the ones that were set up at the falling edge before.
    // An input transaction feeds the prediction, an output transaction is checked.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                board.take_item(in_ch.operation, in_ch.phase_increment,
                                in_ch.start_amplitude);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                board.check_sample(out_ch.sample, out_ch.silent);
            end
        end
    end

    // Sample receiver. Ready is redrawn at every falling edge from the current
    // idle percentage, except during a requested long hold-off, which keeps
    // ready low so that the pipeline fills up and pushes back on the input.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one transaction: optional idle cycles first, then valid with the
    // payload at a falling edge, held until a rising edge sees ready. Valid is
    // left high on return, so valid does not drop between back-to-back items.
    task automatic send_item(input logic operation, input logic [PHASE_W-1:0] increment,
                             input logic [15:0] amplitude);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid           = 1'b1;
        in_ch.operation       = operation;
        in_ch.phase_increment = increment;
        in_ch.start_amplitude = amplitude;
        do begin
            @(posedge clk);
        end while (in_ch.ready !== 1'b1);
    endtask

    // Stops offering items and waits until every expected sample is out. A
    // trigger returns nothing, so a settling wait afterwards covers one still in flight.
    task automatic drain_block();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (board.pending() > 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input dstg_pkg::t_cfg_index index, input logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        board.set_register(index, value);
    endtask

    // Start amplitudes lean toward small values and the current threshold, so
    // that tones reach silence and the threshold crossing gets exercised.
    function automatic logic [15:0] pick_amplitude();
        int near;
        case ($urandom_range(3))
            0, 1: return 16'($urandom);
            2: return 16'($urandom_range(63));
            default: begin
                near = int'(board.silence_threshold) + int'($urandom_range(8)) - 4;
                if (near < 0) begin
                    near = 0;
                end
                if (near > 65535) begin
                    near = 65535;
                end
                return 16'(near);
            end
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] pick_increment();
        case ($urandom_range(3))
            0: return 32'($urandom_range(32'h0100_0000));
            1: return ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly ticks, with a trigger now and then that starts a fresh tone.
    // Ticks carry random payloads, which the block has to ignore.
    task automatic send_random_items(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 9) begin
                send_item(dstg_pkg::OP_TRIGGER, pick_increment(), pick_amplitude());
            end else begin
                send_item(dstg_pkg::OP_TICK, $urandom, 16'($urandom));
            end
        end
    endtask

    initial begin
        int seg;
        board           = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = dstg_pkg::CFG_DECAY_FACTOR;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = dstg_pkg::OP_TICK;
        in_ch.phase_increment = '0;
        in_ch.start_amplitude = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // First phase: the sender idles a little, the receiver a lot.
        send_idle_pct = 24;
        recv_idle_pct = 62;

        // Directed part with the reset register values.
        // Right after reset the envelope is zero, below the default threshold.
        send_item(dstg_pkg::OP_TICK, 32'h0, 16'h0);
        // Full amplitude at a quarter turn per sample walks through all four
        // quadrants, so negative samples show the floor rounding.
        send_item(dstg_pkg::OP_TRIGGER, 32'h4000_0000, 16'hFFFF);
        repeat (5) send_item(dstg_pkg::OP_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        // Largest step: the phase goes back by one unit and wraps.
        send_item(dstg_pkg::OP_TRIGGER, 32'hFFFF_FFFF, 16'h8000);
        repeat (3) send_item(dstg_pkg::OP_TICK, 32'h0, 16'h0);
        // Envelope just below the threshold gives a silent tick.
        send_item(dstg_pkg::OP_TRIGGER, 32'h0, 16'd6);
        send_item(dstg_pkg::OP_TICK, $urandom, 16'($urandom));
        // Envelope equal to the threshold still sounds; the decay then drops
        // it below, and the following ticks are silent.
        send_item(dstg_pkg::OP_TRIGGER, 32'h0040_0000, 16'd7);
        repeat (3) send_item(dstg_pkg::OP_TICK, $urandom, 16'($urandom));
        // Tiny envelope with an odd half-turn step.
        send_item(dstg_pkg::OP_TRIGGER, 32'h8000_0001, 16'h0001);
        send_item(dstg_pkg::OP_TICK, 32'h0, 16'h0);
        send_item(dstg_pkg::OP_TRIGGER, 32'h1234_5678, 16'hFFFF);
        repeat (3) send_item(dstg_pkg::OP_TICK, $urandom, 16'($urandom));

        // Random part in segments. Between segments the block is drained, and
        // the registers are rewritten, extremes included. The idle pattern
        // flips after two segments and is switched off for the last two.
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            drain_block();
            case (seg)
                0: begin
                    write_reg(dstg_pkg::CFG_DECAY_FACTOR, 16'h0000);
                    write_reg(dstg_pkg::CFG_SILENCE_THRESHOLD, 16'h0000);
                end
                1: begin
                    write_reg(dstg_pkg::CFG_DECAY_FACTOR, 16'hFFFF);
                    write_reg(dstg_pkg::CFG_SILENCE_THRESHOLD, 16'hFFFF);
                    // Writes past the register list must not change anything.
                    write_reg(CFG_SPARE_A, 16'h0000);
                    write_reg(CFG_SPARE_B, 16'h1234);
                end
                2: begin
                    send_idle_pct = 62;
                    recv_idle_pct = 24;
                    write_reg(dstg_pkg::CFG_DECAY_FACTOR, 16'($urandom));
                    write_reg(dstg_pkg::CFG_SILENCE_THRESHOLD, 16'($urandom_range(300)));
                end
                3: begin
                    write_reg(dstg_pkg::CFG_DECAY_FACTOR, 16'd60000);
                    write_reg(dstg_pkg::CFG_SILENCE_THRESHOLD, 16'd1);
                end
                4: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_reg(dstg_pkg::CFG_DECAY_FACTOR, dstg_pkg::DECAY_FACTOR_RESET);
                    write_reg(dstg_pkg::CFG_SILENCE_THRESHOLD,
                              dstg_pkg::SILENCE_THRESHOLD_RESET);
                end
                default: begin
                    write_reg(dstg_pkg::CFG_DECAY_FACTOR, 16'($urandom_range(65535, 50000)));
                    write_reg(dstg_pkg::CFG_SILENCE_THRESHOLD, 16'($urandom_range(2000)));
                end
            endcase
            if (seg == PRESSURE_SEG) begin
                // Mid-segment, the receiver holds off for a long stretch while
                // items keep coming, so the block fills up and stalls its input.
                send_random_items(SEGMENT_ITEMS / 2);
                hold_request = 1'b1;
                send_random_items(SEGMENT_ITEMS - SEGMENT_ITEMS / 2);
            end else begin
                send_random_items(SEGMENT_ITEMS);
            end
        end

        drain_block();
        if (board.error_count == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/dstg_pkg.sv
sv/dstg_in_if.sv
sv/dstg_out_if.sv
sv/decaying_sine_tone_generator_top.sv
sv/dstg_checker.sv
tb/tb.sv
